### sv/stg_pkg.sv
// Shared constants, types and codes for the shaded text glyph renderer.
package stg_pkg;

  localparam int FB_WIDTH    = 320;
  localparam int FB_HEIGHT   = 240;
  localparam int GLYPH_COUNT = 96;

  localparam int FONT_DEPTH = GLYPH_COUNT * 3;
  localparam int FIDX_W     = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
  localparam int OFF_W      = $clog2(FB_WIDTH * FB_HEIGHT);

  localparam int COORD_W = 10;
  localparam int ADDR_W  = 24;
  localparam int COLOR_W = 16;
  localparam int CODE_W  = 8;
  localparam int INDEX_W = 9;
  localparam int BYTE_W  = 8;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [COORD_W-1:0] PEN_MAX  = 10'd1023;
  localparam logic [COORD_W-1:0] PEN_STEP = 10'd5;

  localparam logic [COLOR_W-1:0] TEXT_COLOR_RST   = 16'hFFFF;
  localparam logic [COLOR_W-1:0] SHADOW_COLOR_RST = 16'h0001;
  localparam logic [ADDR_W-1:0]  FRAME_BASE_RST   = 24'h000000;

  localparam logic [1:0] REG_TEXT_COLOR   = 2'd0;
  localparam logic [1:0] REG_SHADOW_COLOR = 2'd1;
  localparam logic [1:0] REG_FRAME_BASE   = 2'd2;

  localparam logic ACT_FONT_WRITE = 1'b0;
  localparam logic ACT_RENDER     = 1'b1;

  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_DEL   = 8'h7F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] text_color;
    logic [COLOR_W-1:0] shadow_color;
    logic [ADDR_W-1:0]  frame_base;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic accept;
    logic read;
    logic scan;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_action;
    logic glyph_ok;
    logic read_done;
    logic slot_last;
    logic adv;
    logic cand_valid;
  } sts_t;

endpackage

### sv/stg_if.sv
// Valid/ready channel interfaces for character items and pixel writes.
interface stg_in_if
  import stg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               action;
  logic [INDEX_W-1:0] font_index;
  logic [BYTE_W-1:0]  font_byte;
  logic [CODE_W-1:0]  char_code;
  logic               first;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;

  modport source (output valid, action, font_index, font_byte, char_code, first,
                  start_x, start_y, input ready);
  modport sink (input valid, action, font_index, font_byte, char_code, first,
                start_x, start_y, output ready);
endinterface

interface stg_out_if
  import stg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;
  logic               last;
  logic [COORD_W-1:0] pen_after;

  modport source (output valid, pixel_address, pixel_color, last, pen_after,
                  input ready);
  modport sink (input valid, pixel_address, pixel_color, last, pen_after,
                output ready);
endinterface

### sv/shaded_text_glyph_renderer.sv
// Top level of the shaded text glyph renderer.
//
//   port group   direction  transaction
//   in_ch        sink       font byte write or one character to render
//   out_ch       source     one pixel write (address, color, last, pen)
//   psel..       APB slave  text_color, shadow_color, frame_base
//
// A font write is taken in the idle state. A drawable character is accepted, then
// its 3 font bytes are fetched (one memory read port), 48 pixel slots are scanned
// (one pixel slot per cycle over both passes while out_ch does not stall) and
// any pending write is drained as the last one. Space and codes with no glyph
// are taken in the idle state and are not drawn. out_ch stalls freeze the scan.
// rst_n is synchronous; the font store holds no reset state.
module shaded_text_glyph_renderer
  import stg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  stg_in_if.sink             in_ch,
  stg_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  stg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  stg_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

### sv/stg_regs.sv
// APB-style configuration register block.
module stg_regs
  import stg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_color   <= TEXT_COLOR_RST;
      cfg_r.shadow_color <= SHADOW_COLOR_RST;
      cfg_r.frame_base   <= FRAME_BASE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TEXT_COLOR:   cfg_r.text_color   <= pwdata[COLOR_W-1:0];
        REG_SHADOW_COLOR: cfg_r.shadow_color <= pwdata[COLOR_W-1:0];
        REG_FRAME_BASE:   cfg_r.frame_base   <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TEXT_COLOR:   prdata = PDATA_W'(cfg_r.text_color);
      REG_SHADOW_COLOR: prdata = PDATA_W'(cfg_r.shadow_color);
      REG_FRAME_BASE:   prdata = PDATA_W'(cfg_r.frame_base);
      default:          prdata = '0;
    endcase
  end

endmodule

### sv/stg_ctrl.sv
// Sequencer: item intake, font fetch, pixel scan and drain.
module stg_ctrl
  import stg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (sts.in_valid && sts.in_action == ACT_RENDER && sts.glyph_ok) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (sts.read_done) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.adv && sts.slot_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.adv && !sts.cand_valid) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.ready  = 1'b1;
        cmd.accept = sts.in_valid;
      end
      ST_READ:  cmd.read  = 1'b1;
      ST_SCAN:  cmd.scan  = 1'b1;
      ST_DRAIN: cmd.flush = 1'b1;
      default: ;
    endcase
  end

endmodule

### sv/stg_datapath.sv
// Font store, pen, pixel scan, address pipeline and output register.
module stg_datapath
  import stg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  cmd_t cmd,
  output sts_t sts,
  stg_in_if.sink   in_ch,
  stg_out_if.source out_ch
);

  localparam logic [CODE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CODE_W-1:0] CH_LO_J  = 8'h6A;
  localparam logic [CODE_W-1:0] CH_LO_G  = 8'h67;
  localparam logic [CODE_W-1:0] CH_LO_P  = 8'h70;
  localparam logic [CODE_W-1:0] CH_LO_Q  = 8'h71;
  localparam logic [CODE_W-1:0] CH_LO_Y  = 8'h79;
  localparam logic [CODE_W-1:0] CH_UP_Q  = 8'h51;

  localparam int CW = COORD_W + 1;

  logic [BYTE_W-1:0]  font_mem [FONT_DEPTH];
  logic [BYTE_W-1:0]  mem_q_r;
  logic               rd_v_r;
  logic [1:0]         rd_sel_r;
  logic [1:0]         rd_cnt_r;
  logic [FIDX_W-1:0]  fbase_r;
  logic [BYTE_W-1:0]  bytes_r [3];

  logic [COORD_W-1:0] pen_col_r;
  logic [COORD_W-1:0] pen_row_r;
  logic [COORD_W-1:0] draw_x_r;
  logic [COORD_W-1:0] draw_y_r;
  logic [1:0]         yoffs_r;
  logic [COORD_W-1:0] pen_after_r;

  logic               pass_r;
  logic [4:0]         p_r;

  logic               cand_v_r;
  logic [OFF_W-1:0]   cand_off_r;
  logic [COLOR_W-1:0] cand_color_r;
  logic               pend_v_r;
  logic [ADDR_W-1:0]  pend_addr_r;
  logic [COLOR_W-1:0] pend_color_r;
  logic               out_v_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;
  logic [COORD_W-1:0] out_pen_r;

  logic [CODE_W-1:0]  code;
  logic [CODE_W-1:0]  glyph;
  logic               glyph_ok;
  logic [1:0]         yoffs_c;
  logic [COORD_W-1:0] x_sel;
  logic [COORD_W-1:0] pen_next;
  logic [FIDX_W-1:0]  rd_addr;
  logic               font_wr;
  logic               en;
  logic               shadow;
  logic [BYTE_W-1:0]  bits;
  logic               bit_set;
  logic [CW-1:0]      colp;
  logic [CW-1:0]      col_eff;
  logic [CW-1:0]      row;
  logic               col_ok;
  logic               row_ok;
  logic               hit;
  logic [OFF_W-1:0]   off_c;
  logic [ADDR_W-1:0]  addr_c;

  // item decode
  assign code     = in_ch.char_code;
  assign glyph    = code - CH_SPACE;
  assign glyph_ok = (code > CH_SPACE) && (code <= CH_DEL) &&
                    (32'(glyph) < GLYPH_COUNT);

  always_comb begin
    if (code == CH_LO_J || code == CH_LO_G || code == CH_LO_P ||
        code == CH_LO_Q || code == CH_LO_Y || code == CH_UP_Q) begin
      yoffs_c = 2'd1;
    end else if (code == CH_COMMA) begin
      yoffs_c = 2'd2;
    end else begin
      yoffs_c = 2'd0;
    end
  end

  assign x_sel    = in_ch.first ? in_ch.start_x : pen_col_r;
  assign pen_next = (x_sel > PEN_MAX - PEN_STEP) ? PEN_MAX : x_sel + PEN_STEP;
  assign font_wr  = cmd.accept && in_ch.action == ACT_FONT_WRITE &&
                    32'(in_ch.font_index) < FONT_DEPTH;
  assign rd_addr  = fbase_r + FIDX_W'(rd_cnt_r);

  // font store
  always_ff @(posedge clk) begin
    if (font_wr) font_mem[in_ch.font_index[FIDX_W-1:0]] <= in_ch.font_byte;
    if (cmd.read) mem_q_r <= font_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.read;
    end
  end

  always_ff @(posedge clk) begin
    rd_sel_r <= rd_cnt_r;
    if (rd_v_r) bytes_r[rd_sel_r] <= mem_q_r;
  end

  // pen and per-item context
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_col_r <= '0;
      pen_row_r <= '0;
    end else if (cmd.accept && in_ch.action == ACT_RENDER) begin
      pen_col_r <= pen_next;
      if (in_ch.first) pen_row_r <= in_ch.start_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_ch.action == ACT_RENDER) begin
      draw_x_r    <= x_sel;
      draw_y_r    <= in_ch.first ? in_ch.start_y : pen_row_r;
      yoffs_r     <= yoffs_c;
      pen_after_r <= pen_next;
      fbase_r     <= FIDX_W'(32'(glyph) * 3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
    end else if (cmd.accept) begin
      rd_cnt_r <= '0;
    end else if (cmd.read) begin
      rd_cnt_r <= rd_cnt_r + 2'd1;
    end
  end

  assign en = !out_v_r || out_ch.ready;

  // slot counter: pass 0 shadow, pass 1 front; 24 slots per pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
      p_r    <= '0;
    end else if (cmd.accept) begin
      pass_r <= 1'b0;
      p_r    <= '0;
    end else if (cmd.scan && en) begin
      if (p_r == 5'd23) begin
        p_r    <= '0;
        pass_r <= 1'b1;
      end else begin
        p_r <= p_r + 5'd1;
      end
    end
  end

  assign shadow = !pass_r;

  always_comb begin
    case (p_r[4:3])
      2'd0:    bits = bytes_r[0];
      2'd1:    bits = bytes_r[1];
      2'd2:    bits = bytes_r[2];
      default: bits = '0;
    endcase
  end

  assign bit_set = bits[~p_r[2:0]];
  assign colp    = CW'(draw_x_r) + CW'(p_r[1:0]);
  assign col_eff = colp - CW'(shadow);
  assign row     = CW'(draw_y_r) + CW'(yoffs_r) + CW'(shadow) + CW'(p_r[4:2]);
  assign col_ok  = !(shadow && colp == '0) && (32'(col_eff) < FB_WIDTH);
  assign row_ok  = 32'(row) < FB_HEIGHT;
  assign hit     = cmd.scan && bit_set && col_ok && row_ok;
  assign off_c   = OFF_W'(32'(row[COORD_W-1:0]) * FB_WIDTH +
                          32'(col_eff[COORD_W-1:0]));
  assign addr_c  = cfg.frame_base + ADDR_W'({cand_off_r, 1'b0});

  // candidate -> pending -> output; pending is held back to find the last write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_v_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (en) begin
      cand_v_r <= hit;
      if (cand_v_r) begin
        pend_v_r <= 1'b1;
        out_v_r  <= pend_v_r;
      end else if (cmd.flush && pend_v_r) begin
        pend_v_r <= 1'b0;
        out_v_r  <= 1'b1;
      end else begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cand_off_r   <= off_c;
      cand_color_r <= shadow ? cfg.shadow_color : cfg.text_color;
      if (cand_v_r) begin
        pend_addr_r  <= addr_c;
        pend_color_r <= cand_color_r;
        out_addr_r   <= pend_addr_r;
        out_color_r  <= pend_color_r;
        out_last_r   <= 1'b0;
        out_pen_r    <= pen_after_r;
      end else if (cmd.flush && pend_v_r) begin
        out_addr_r  <= pend_addr_r;
        out_color_r <= pend_color_r;
        out_last_r  <= 1'b1;
        out_pen_r   <= pen_after_r;
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.pixel_address = out_addr_r;
  assign out_ch.pixel_color   = out_color_r;
  assign out_ch.last          = out_last_r;
  assign out_ch.pen_after     = out_pen_r;

  assign in_ch.ready = cmd.ready;

  assign sts.in_valid   = in_ch.valid;
  assign sts.in_action  = in_ch.action;
  assign sts.glyph_ok   = glyph_ok;
  assign sts.read_done  = cmd.read && rd_cnt_r == 2'd2;
  assign sts.slot_last  = pass_r && p_r == 5'd23;
  assign sts.adv        = en;
  assign sts.cand_valid = cand_v_r;

endmodule
